// ===== rtl/nbge_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nbge_pkg
// Shared types and constants of the 2-D direct-sum gravity step core.
// ----------------------------------------------------------------------------
package nbge_pkg;

   localparam int WORD_W       = 48;
   localparam int ALU_W        = 128;
   localparam int RESULT_LIMIT = 16;

   // input item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BODY_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP  = 2'd1;

   localparam logic [31:0] TIME_STEP_RESET = 32'd65536;
   localparam logic [62:0] KICK_CAP        = 63'h4000_0000_0000_0000;

   // one table entry
   typedef struct packed {
      logic        [WORD_W-1:0] mu;
      logic signed [WORD_W-1:0] px;
      logic signed [WORD_W-1:0] py;
      logic signed [WORD_W-1:0] vx;
      logic signed [WORD_W-1:0] vy;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_I,
      ST_RD_J,
      ST_LATCH_J,
      ST_SQ_X,
      ST_SQ_Y,
      ST_CHECK,
      ST_ROOT,
      ST_MI_MUL,
      ST_MI_DIV,
      ST_MJ_MUL,
      ST_MJ_DIV,
      ST_PXI_MUL,
      ST_PXI_DIV,
      ST_PYI_MUL,
      ST_PYI_DIV,
      ST_PXJ_MUL,
      ST_PXJ_DIV,
      ST_PYJ_MUL,
      ST_PYJ_DIV,
      ST_WR_I,
      ST_WR_J,
      ST_NEXT_PAIR,
      ST_RD_P,
      ST_LATCH_P,
      ST_DX_HI,
      ST_DX_LO,
      ST_DY_HI,
      ST_DY_LO,
      ST_WR_P,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/nbge_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nbge_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nbge_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== rtl/nbge_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nbge_alu
// Bit-serial arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root.
// ----------------------------------------------------------------------------
module nbge_alu (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nbge_pkg::alu_ctl_type ctl,
   input  wire logic [127:0]          a,
   input  wire logic [127:0]          b,
   output nbge_pkg::alu_sts_type      sts,
   output logic [127:0]               result
);

   import nbge_pkg::*;

   alu_op_type   op_ff;
   logic [127:0] x_ff, x_in;
   logic [127:0] y_ff, y_in;
   logic [129:0] acc_ff, acc_in;
   logic [127:0] q_ff, q_in;
   logic [7:0]   cnt_ff;
   logic         busy_ff;
   logic         done_ff;

   logic [129:0] rem_sh;
   logic [129:0] trial;

   // one iteration of the selected operation
   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      acc_in = acc_ff;
      q_in   = q_ff;
      rem_sh = '0;
      trial  = '0;
      case (op_ff)
         ALU_MUL: begin
            acc_in = {acc_ff[128:0], 1'b0} + (y_ff[63] ? {2'b00, x_ff} : 130'd0);
            y_in   = {y_ff[126:0], 1'b0};
         end
         ALU_DIV: begin
            rem_sh = {acc_ff[128:0], x_ff[127]};
            x_in   = {x_ff[126:0], 1'b0};
            if (rem_sh >= {2'b00, y_ff}) begin
               acc_in = rem_sh - {2'b00, y_ff};
               q_in   = {q_ff[126:0], 1'b1};
            end else begin
               acc_in = rem_sh;
               q_in   = {q_ff[126:0], 1'b0};
            end
         end
         ALU_SQRT: begin
            rem_sh = {acc_ff[127:0], x_ff[127:126]};
            trial  = {q_ff, 2'b01};
            x_in   = {x_ff[125:0], 2'b00};
            if (rem_sh >= trial) begin
               acc_in = rem_sh - trial;
               q_in   = {q_ff[126:0], 1'b1};
            end else begin
               acc_in = rem_sh;
               q_in   = {q_ff[126:0], 1'b0};
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= (ctl.op == ALU_DIV) ? 8'd128 : 8'd64;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 8'd1;
            if (cnt_ff == 8'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         op_ff  <= ctl.op;
         x_ff   <= a;
         y_ff   <= b;
         acc_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         acc_ff <= acc_in;
         q_ff   <= q_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = (op_ff == ALU_MUL) ? acc_ff[127:0] : q_ff;

endmodule
`default_nettype wire

// ===== rtl/nbody_gravity_euler_step_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nbody_gravity_euler_step_core
// 2-D direct-sum gravity with a semi-implicit Euler step in fixed point.
// Timing: a load is written to the table as it is accepted. A step computes the
//   force of each body pair with nonzero distance (a coincident pair is skipped),
//   then the position pass per body, all on the one shared bit-serial unit.
// Throughput: one item at a time; a load every cycle while idle.
// Reset: control, body_count (0) and time_step (1.0 s) are set; table unset.
// ----------------------------------------------------------------------------
module nbody_gravity_euler_step_core #(
   parameter int MAX_BODIES = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // input channel
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_kind,
   input  wire logic [3:0]              req_body_index,
   input  wire logic [47:0]             req_grav_param,
   input  wire logic signed [47:0]      req_load_pos_x,
   input  wire logic signed [47:0]      req_load_pos_y,
   input  wire logic signed [47:0]      req_load_vel_x,
   input  wire logic signed [47:0]      req_load_vel_y,
   // result channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [3:0]                   rsp_out_index,
   output logic signed [47:0]           rsp_out_pos_x,
   output logic signed [47:0]           rsp_out_pos_y,
   output logic signed [47:0]           rsp_out_vel_x,
   output logic signed [47:0]           rsp_out_vel_y,
   output logic                         rsp_last_body,
   // register port
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [nbge_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]             csr_wdata
);

   import nbge_pkg::*;

   localparam int AW      = $clog2(MAX_BODIES);
   localparam int N_LIMIT = (MAX_BODIES < RESULT_LIMIT) ? MAX_BODIES : RESULT_LIMIT;

   // ---------------------------------------------------------------------
   // helpers
   function automatic logic signed [47:0] sat_add(input logic signed [47:0] v,
                                                  input logic [62:0] c,
                                                  input logic neg);
      logic signed [64:0] cx;
      logic signed [64:0] sum;
      cx  = neg ? -$signed({2'b00, c}) : $signed({2'b00, c});
      sum = $signed({{17{v[47]}}, v}) + cx;
      if (sum[64:47] != {18{sum[64]}}) begin
         return sum[64] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end
      return sum[47:0];
   endfunction

   function automatic logic [47:0] mag49(input logic signed [48:0] d);
      logic [48:0] m;
      m = d[48] ? -d : d;
      return m[47:0];
   endfunction

   function automatic logic [47:0] mag48(input logic signed [47:0] v);
      logic [47:0] m;
      m = v[47] ? -v : v;
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // registers
   state_type state_ff, state_in;
   logic [4:0]  cnt_ff;
   logic [31:0] dt_ff;
   logic [4:0]  n_ff;
   logic [4:0]  i_ff;
   logic [4:0]  j_ff;
   logic        issued_ff;
   rec_type     rec_i_ff;
   rec_type     rec_j_ff;
   logic signed [48:0] dx_ff;
   logic signed [48:0] dy_ff;
   logic [97:0]  r2_ff;
   logic [49:0]  r_ff;
   logic [111:0] tmp_ff;
   logic [62:0]  mi_ff;
   logic [62:0]  mj_ff;

   logic         rsp_valid_ff;
   logic [3:0]   out_index_ff;
   logic signed [47:0] out_px_ff, out_py_ff, out_vx_ff, out_vy_ff;
   logic         out_last_ff;

   // ---------------------------------------------------------------------
   // combinational signals
   logic        req_xfer;
   logic        csr_xfer;
   logic [4:0]  n_calc;
   logic        load_we;
   logic        ram_we;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] ram_raddr;
   rec_type     ram_wdata;
   rec_type     ram_rdata;
   logic [REC_W-1:0] ram_rdata_raw;
   alu_ctl_type alu_ctl;
   alu_sts_type alu_sts;
   logic [127:0] alu_a, alu_b, alu_res;
   logic        op_state;
   logic        emit_load;
   logic        more_j, more_i, more_p;
   logic [47:0] dxm, dym, vxm, vym;
   logic [62:0] kick_q;
   logic [62:0] disp;

   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign n_calc    = (cnt_ff > 5'(N_LIMIT)) ? 5'(N_LIMIT) : cnt_ff;
   assign load_we   = req_xfer && (req_kind == KIND_LOAD)
                      && (32'(req_body_index) < MAX_BODIES);

   assign more_j = ({1'b0, j_ff} + 6'd1) < {1'b0, n_ff};
   assign more_i = ({1'b0, i_ff} + 6'd2) < {1'b0, n_ff};
   assign more_p = ({1'b0, i_ff} + 6'd1) < {1'b0, n_ff};

   assign dxm = mag49(dx_ff);
   assign dym = mag49(dy_ff);
   assign vxm = mag48(rec_i_ff.vx);
   assign vym = mag48(rec_i_ff.vy);

   assign kick_q = (alu_res > {65'd0, KICK_CAP}) ? KICK_CAP : alu_res[62:0];
   assign disp   = {14'd0, tmp_ff[48:0]} + {31'd0, alu_res[63:32]};

   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // ---------------------------------------------------------------------
   // table memory and arithmetic unit
   assign ram_rdata = rec_type'(ram_rdata_raw);

   nbge_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_BODIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata_raw)
   );

   nbge_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .a      (alu_a),
      .b      (alu_b),
      .sts    (alu_sts),
      .result (alu_res)
   );

   // ---------------------------------------------------------------------
   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_kind == KIND_STEP)) begin
               if (n_calc >= 5'd2) begin
                  state_in = ST_RD_I;
               end else if (n_calc == 5'd1) begin
                  state_in = ST_RD_P;
               end
            end
         end
         ST_RD_I:    state_in = ST_RD_J;
         ST_RD_J:    state_in = ST_LATCH_J;
         ST_LATCH_J: state_in = ST_SQ_X;
         ST_SQ_X:    if (alu_sts.done) state_in = ST_SQ_Y;
         ST_SQ_Y:    if (alu_sts.done) state_in = ST_CHECK;
         ST_CHECK:   state_in = (r2_ff == '0) ? ST_NEXT_PAIR : ST_ROOT;
         ST_ROOT:    if (alu_sts.done) state_in = ST_MI_MUL;
         ST_MI_MUL:  if (alu_sts.done) state_in = ST_MI_DIV;
         ST_MI_DIV:  if (alu_sts.done) state_in = ST_MJ_MUL;
         ST_MJ_MUL:  if (alu_sts.done) state_in = ST_MJ_DIV;
         ST_MJ_DIV:  if (alu_sts.done) state_in = ST_PXI_MUL;
         ST_PXI_MUL: if (alu_sts.done) state_in = ST_PXI_DIV;
         ST_PXI_DIV: if (alu_sts.done) state_in = ST_PYI_MUL;
         ST_PYI_MUL: if (alu_sts.done) state_in = ST_PYI_DIV;
         ST_PYI_DIV: if (alu_sts.done) state_in = ST_PXJ_MUL;
         ST_PXJ_MUL: if (alu_sts.done) state_in = ST_PXJ_DIV;
         ST_PXJ_DIV: if (alu_sts.done) state_in = ST_PYJ_MUL;
         ST_PYJ_MUL: if (alu_sts.done) state_in = ST_PYJ_DIV;
         ST_PYJ_DIV: if (alu_sts.done) state_in = ST_WR_I;
         ST_WR_I:    state_in = ST_WR_J;
         ST_WR_J:    state_in = ST_NEXT_PAIR;
         ST_NEXT_PAIR: state_in = (more_j || more_i) ? ST_RD_I : ST_RD_P;
         ST_RD_P:    state_in = ST_LATCH_P;
         ST_LATCH_P: state_in = ST_DX_HI;
         ST_DX_HI:   if (alu_sts.done) state_in = ST_DX_LO;
         ST_DX_LO:   if (alu_sts.done) state_in = ST_DY_HI;
         ST_DY_HI:   if (alu_sts.done) state_in = ST_DY_LO;
         ST_DY_LO:   if (alu_sts.done) state_in = ST_WR_P;
         ST_WR_P:    state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_load) begin
               state_in = more_p ? ST_RD_P : ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // outputs of the sequencer: memory port and unit operands
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      op_state    = 1'b0;
      alu_ctl.op  = ALU_MUL;
      alu_a       = '0;
      alu_b       = '0;
      ram_we      = load_we;
      ram_waddr   = AW'(req_body_index);
      ram_wdata   = '{mu: req_grav_param, px: req_load_pos_x, py: req_load_pos_y,
                      vx: req_load_vel_x, vy: req_load_vel_y};
      ram_raddr   = AW'(i_ff);
      case (state_ff)
         ST_RD_J: ram_raddr = AW'(j_ff);
         ST_SQ_X: begin
            op_state = 1'b1;
            alu_a    = {80'd0, dxm};
            alu_b    = {80'd0, dxm};
         end
         ST_SQ_Y: begin
            op_state = 1'b1;
            alu_a    = {80'd0, dym};
            alu_b    = {80'd0, dym};
         end
         ST_ROOT: begin
            op_state   = 1'b1;
            alu_ctl.op = ALU_SQRT;
            alu_a      = {30'd0, r2_ff};
         end
         ST_MI_MUL: begin
            op_state = 1'b1;
            alu_a    = {80'd0, rec_j_ff.mu};
            alu_b    = {96'd0, dt_ff};
         end
         ST_MJ_MUL: begin
            op_state = 1'b1;
            alu_a    = {80'd0, rec_i_ff.mu};
            alu_b    = {96'd0, dt_ff};
         end
         ST_MI_DIV, ST_MJ_DIV: begin
            op_state   = 1'b1;
            alu_ctl.op = ALU_DIV;
            alu_a      = {tmp_ff[103:0], 24'd0};
            alu_b      = {30'd0, r2_ff};
         end
         ST_PXI_MUL: begin
            op_state = 1'b1;
            alu_a    = {65'd0, mi_ff};
            alu_b    = {80'd0, dxm};
         end
         ST_PYI_MUL: begin
            op_state = 1'b1;
            alu_a    = {65'd0, mi_ff};
            alu_b    = {80'd0, dym};
         end
         ST_PXJ_MUL: begin
            op_state = 1'b1;
            alu_a    = {65'd0, mj_ff};
            alu_b    = {80'd0, dxm};
         end
         ST_PYJ_MUL: begin
            op_state = 1'b1;
            alu_a    = {65'd0, mj_ff};
            alu_b    = {80'd0, dym};
         end
         ST_PXI_DIV, ST_PYI_DIV, ST_PXJ_DIV, ST_PYJ_DIV: begin
            op_state   = 1'b1;
            alu_ctl.op = ALU_DIV;
            alu_a      = {16'd0, tmp_ff};
            alu_b      = {78'd0, r_ff};
         end
         ST_DX_HI: begin
            op_state = 1'b1;
            alu_a    = {112'd0, vxm[47:32]};
            alu_b    = {96'd0, dt_ff};
         end
         ST_DX_LO: begin
            op_state = 1'b1;
            alu_a    = {96'd0, vxm[31:0]};
            alu_b    = {96'd0, dt_ff};
         end
         ST_DY_HI: begin
            op_state = 1'b1;
            alu_a    = {112'd0, vym[47:32]};
            alu_b    = {96'd0, dt_ff};
         end
         ST_DY_LO: begin
            op_state = 1'b1;
            alu_a    = {96'd0, vym[31:0]};
            alu_b    = {96'd0, dt_ff};
         end
         ST_WR_I, ST_WR_P: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(i_ff);
            ram_wdata = rec_i_ff;
         end
         ST_WR_J: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(j_ff);
            ram_wdata = rec_j_ff;
         end
         default: begin
            op_state = 1'b0;
         end
      endcase
      alu_ctl.start = op_state && !issued_ff;
   end

   // ---------------------------------------------------------------------
   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         cnt_ff       <= '0;
         dt_ff        <= TIME_STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (alu_ctl.start) begin
            issued_ff <= 1'b1;
         end else if (alu_sts.done) begin
            issued_ff <= 1'b0;
         end
         if (csr_xfer) begin
            case (csr_index)
               CSR_BODY_COUNT: cnt_ff <= csr_wdata[4:0];
               CSR_TIME_STEP:  dt_ff  <= csr_wdata;
               default:        cnt_ff <= cnt_ff;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            n_ff <= n_calc;
            i_ff <= 5'd0;
            j_ff <= 5'd1;
         end
         ST_RD_J: rec_i_ff <= ram_rdata;
         ST_LATCH_J: begin
            rec_j_ff <= ram_rdata;
            dx_ff    <= $signed({ram_rdata.px[47], ram_rdata.px})
                        - $signed({rec_i_ff.px[47], rec_i_ff.px});
            dy_ff    <= $signed({ram_rdata.py[47], ram_rdata.py})
                        - $signed({rec_i_ff.py[47], rec_i_ff.py});
         end
         ST_SQ_X:   if (alu_sts.done) r2_ff <= alu_res[97:0];
         ST_SQ_Y:   if (alu_sts.done) r2_ff <= r2_ff + alu_res[97:0];
         ST_ROOT:   if (alu_sts.done) r_ff <= alu_res[49:0];
         ST_MI_MUL, ST_MJ_MUL, ST_PXI_MUL, ST_PYI_MUL, ST_PXJ_MUL, ST_PYJ_MUL,
         ST_DX_HI, ST_DY_HI: begin
            if (alu_sts.done) tmp_ff <= alu_res[111:0];
         end
         ST_MI_DIV: if (alu_sts.done) mi_ff <= kick_q;
         ST_MJ_DIV: if (alu_sts.done) mj_ff <= kick_q;
         // body i is pulled toward j, body j the opposite way
         ST_PXI_DIV: begin
            if (alu_sts.done) rec_i_ff.vx <= sat_add(rec_i_ff.vx, alu_res[62:0], dx_ff[48]);
         end
         ST_PYI_DIV: begin
            if (alu_sts.done) rec_i_ff.vy <= sat_add(rec_i_ff.vy, alu_res[62:0], dy_ff[48]);
         end
         ST_PXJ_DIV: begin
            if (alu_sts.done) rec_j_ff.vx <= sat_add(rec_j_ff.vx, alu_res[62:0], !dx_ff[48]);
         end
         ST_PYJ_DIV: begin
            if (alu_sts.done) rec_j_ff.vy <= sat_add(rec_j_ff.vy, alu_res[62:0], !dy_ff[48]);
         end
         ST_NEXT_PAIR: begin
            if (more_j) begin
               j_ff <= j_ff + 5'd1;
            end else if (more_i) begin
               i_ff <= i_ff + 5'd1;
               j_ff <= i_ff + 5'd2;
            end else begin
               i_ff <= 5'd0;
            end
         end
         ST_LATCH_P: rec_i_ff <= ram_rdata;
         // displacement = |v| * dt / 2^32, from the 16-bit high and 32-bit low parts of |v|
         ST_DX_LO: begin
            if (alu_sts.done) rec_i_ff.px <= sat_add(rec_i_ff.px, disp, rec_i_ff.vx[47]);
         end
         ST_DY_LO: begin
            if (alu_sts.done) rec_i_ff.py <= sat_add(rec_i_ff.py, disp, rec_i_ff.vy[47]);
         end
         ST_EMIT: begin
            if (emit_load) begin
               i_ff <= i_ff + 5'd1;
            end
         end
         default: begin
            n_ff <= n_ff;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (emit_load) begin
         out_index_ff <= i_ff[3:0];
         out_px_ff    <= rec_i_ff.px;
         out_py_ff    <= rec_i_ff.py;
         out_vx_ff    <= rec_i_ff.vx;
         out_vy_ff    <= rec_i_ff.vy;
         out_last_ff  <= !more_p;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = out_index_ff;
   assign rsp_out_pos_x = out_px_ff;
   assign rsp_out_pos_y = out_py_ff;
   assign rsp_out_vel_x = out_vx_ff;
   assign rsp_out_vel_y = out_vy_ff;
   assign rsp_last_body = out_last_ff;

   // ---------------------------------------------------------------------
   // assertions
   a_alu_start_idle: assert property (@(posedge clock) disable iff (reset)
      alu_ctl.start |-> !alu_sts.busy)
      else $error("arithmetic unit started while busy");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_I) |-> (i_ff < j_ff && j_ff < n_ff))
      else $error("pair indexes out of order");

   a_write_slot: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE || state_ff == ST_WR_I ||
                  state_ff == ST_WR_J || state_ff == ST_WR_P))
      else $error("table written outside a write slot");

   a_no_emit_during_pairs: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_EMIT)
      else $error("result raised outside the emit step");

endmodule
`default_nettype wire
